// ===== design/gbts_pkg.sv =====
// ----------------------------------------------------------------------------
// Gap buffer text store package
// Shared request kinds, status codes and the queued request record.
// ----------------------------------------------------------------------------
package gbts_pkg;

   localparam int FieldWidth = 13;

   typedef enum logic [1:0] {
      KIND_INSERT = 2'd0,
      KIND_DELETE = 2'd1,
      KIND_READ   = 2'd2,
      KIND_BAD    = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   typedef struct packed {
      kind_type              kind;
      logic [FieldWidth-1:0] position;
      logic [7:0]            data_byte;
      logic [FieldWidth-1:0] length;
   } item_type;

endpackage

// ===== design/gap_buffer_text_store_top.sv =====
// ----------------------------------------------------------------------------
// Gap buffer text store
// Fixed-capacity editable text held as a gap buffer in one byte memory.
// ----------------------------------------------------------------------------
// Usage:
// The request channel (req_*) carries one word per edit: insert one byte,
// delete a run of bytes, or read one byte at a logical position. The result
// channel (rsp_*) returns exactly one word per request, in order, with a
// status, the byte read and the text length after the request.
// A two-entry queue sits behind the request port, so requests are taken
// while the engine works or while a result waits for the receiver.
// Timing: a rejected request answers straight from the idle state, a read
// passes through S_READ and S_RDOUT, and an insert or delete alternates
// S_SEEK and S_SHIFT once for each byte the gap has to travel; each byte
// moved costs one memory read and one memory write, which sets the throughput.
// While rsp_stall is high the result word holds and the engine waits; the
// queue keeps accepting until it is full, then req_stall rises.
// Reset empties the text: the gap spans the whole memory. Memory contents
// are not cleared, since only written bytes are ever read back.
// ----------------------------------------------------------------------------
module gap_buffer_text_store_top #(
   parameter int CAPACITY = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [12:0] req_position,
   input  logic [7:0]  req_data_byte,
   input  logic [12:0] req_length,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_read_byte,
   output logic [12:0] rsp_content_length
);
   import gbts_pkg::*;

   logic     item_valid;
   logic     item_pop;
   item_type item;

   // The front end decodes and queues request words.
   gbts_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_mode      (req_mode),
      .req_position  (req_position),
      .req_data_byte (req_data_byte),
      .req_length    (req_length),
      .item_valid    (item_valid),
      .item          (item),
      .item_pop      (item_pop)
   );

   // The back end owns the memory, moves the gap and registers the result.
   gbts_back #(
      .CAPACITY (CAPACITY)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .item_valid         (item_valid),
      .item               (item),
      .item_pop           (item_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_read_byte      (rsp_read_byte),
      .rsp_content_length (rsp_content_length)
   );

endmodule

// ===== design/gbts_front.sv =====
// ----------------------------------------------------------------------------
// Gap buffer front end
// Accepts request words, decodes the kind and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module gbts_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_mode,
   input  logic [12:0]        req_position,
   input  logic [7:0]         req_data_byte,
   input  logic [12:0]        req_length,
   output logic               item_valid,
   output gbts_pkg::item_type item,
   input  logic               item_pop
);
   import gbts_pkg::*;

   item_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;
   item_type   decoded;

   always_comb begin
      case (req_mode)
         2'd0:    decoded.kind = KIND_INSERT;
         2'd1:    decoded.kind = KIND_DELETE;
         2'd2:    decoded.kind = KIND_READ;
         default: decoded.kind = KIND_BAD;
      endcase
      decoded.position  = req_position;
      decoded.data_byte = req_data_byte;
      decoded.length    = req_length;
   end

   assign req_stall  = (count_ff == 2'd2);
   assign push       = req_valid && !req_stall;
   assign item_valid = (count_ff != 2'd0);
   assign pop        = item_pop && item_valid;
   assign item       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= decoded;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== design/gbts_back.sv =====
// ----------------------------------------------------------------------------
// Gap buffer back end
// Owns the text memory and gap pointers, moves the gap and drives results.
// ----------------------------------------------------------------------------
module gbts_back #(
   parameter int CAPACITY = 4096
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   input  gbts_pkg::item_type item,
   output logic               item_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic [7:0]         rsp_read_byte,
   output logic [12:0]        rsp_content_length
);
   import gbts_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int PW = $clog2(CAPACITY + 1);
   localparam int CW = (PW > FieldWidth + 1) ? PW : FieldWidth + 1;

   typedef enum logic [2:0] {
      S_IDLE, S_SEEK, S_SHIFT, S_READ, S_RDOUT
   } state_type;

   logic [7:0]    mem [CAPACITY];
   logic [7:0]    rdata_ff;
   logic [AW-1:0] rd_addr;

   state_type     state_ff;
   logic [PW-1:0] begin_ff, finish_ff, tgt_ff;
   logic [AW-1:0] addr_ff;
   item_type      cur_ff;
   logic          rsp_valid_ff;
   status_type    status_ff;
   logic [7:0]    rbyte_ff;

   logic [CW-1:0] held, pos_w, len_w, gap_w;
   logic          going_down;

   assign held  = CW'(begin_ff) + CW'(CAPACITY) - CW'(finish_ff);
   assign pos_w = CW'(item.position);
   assign len_w = CW'(item.length);
   assign gap_w = CW'(finish_ff) - CW'(begin_ff);
   assign going_down = (tgt_ff < begin_ff);

   assign item_pop           = (state_ff == S_IDLE) && !rsp_valid_ff && item_valid;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_read_byte      = rbyte_ff;
   assign rsp_content_length = held[FieldWidth-1:0];

   // Source of the next byte to move across the gap, or the read address.
   always_comb begin
      if (state_ff == S_READ) begin
         rd_addr = addr_ff;
      end else if (going_down) begin
         rd_addr = AW'(begin_ff - PW'(1));
      end else begin
         rd_addr = finish_ff[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[rd_addr];
      if (state_ff == S_SHIFT) begin
         if (going_down) begin
            mem[AW'(finish_ff - PW'(1))] <= rdata_ff;
         end else begin
            mem[begin_ff[AW-1:0]] <= rdata_ff;
         end
      end else if (state_ff == S_SEEK && begin_ff == tgt_ff
                   && cur_ff.kind == KIND_INSERT) begin
         mem[begin_ff[AW-1:0]] <= cur_ff.data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         begin_ff     <= '0;
         finish_ff    <= PW'(CAPACITY);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (item_pop) begin
                  cur_ff    <= item;
                  tgt_ff    <= PW'(pos_w);
                  rbyte_ff  <= 8'd0;
                  status_ff <= STATUS_OK;
                  case (item.kind)
                     KIND_INSERT: begin
                        if (pos_w > held) begin
                           status_ff    <= STATUS_RANGE;
                           rsp_valid_ff <= 1'b1;
                        end else if (begin_ff == finish_ff) begin
                           status_ff    <= STATUS_FULL;
                           rsp_valid_ff <= 1'b1;
                        end else begin
                           state_ff <= S_SEEK;
                        end
                     end
                     KIND_DELETE: begin
                        if (pos_w + len_w > held) begin
                           status_ff    <= STATUS_RANGE;
                           rsp_valid_ff <= 1'b1;
                        end else begin
                           state_ff <= S_SEEK;
                        end
                     end
                     KIND_READ: begin
                        if (pos_w >= held) begin
                           status_ff    <= STATUS_RANGE;
                           rsp_valid_ff <= 1'b1;
                        end else begin
                           if (pos_w < CW'(begin_ff)) begin
                              addr_ff <= AW'(pos_w);
                           end else begin
                              addr_ff <= AW'(pos_w + gap_w);
                           end
                           state_ff <= S_READ;
                        end
                     end
                     default: begin
                        status_ff    <= STATUS_RANGE;
                        rsp_valid_ff <= 1'b1;
                     end
                  endcase
               end
            end
            S_SEEK: begin
               if (begin_ff == tgt_ff) begin
                  if (cur_ff.kind == KIND_INSERT) begin
                     begin_ff <= begin_ff + PW'(1);
                  end else begin
                     finish_ff <= PW'(CW'(finish_ff) + CW'(cur_ff.length));
                  end
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end else begin
                  state_ff <= S_SHIFT;
               end
            end
            S_SHIFT: begin
               if (going_down) begin
                  begin_ff  <= begin_ff - PW'(1);
                  finish_ff <= finish_ff - PW'(1);
               end else begin
                  begin_ff  <= begin_ff + PW'(1);
                  finish_ff <= finish_ff + PW'(1);
               end
               state_ff <= S_SEEK;
            end
            S_READ: begin
               state_ff <= S_RDOUT;
            end
            S_RDOUT: begin
               rbyte_ff     <= rdata_ff;
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== verif/gap_buffer_text_store_top_tb.sv =====
// ----------------------------------------------------------------------------
// Gap buffer text store testbench
// Drives insert, delete and read requests with random idling on both sides,
// predicts every result word from its own copy of the text and the gap, and
// compares the words that come back in order, field by field.
// ----------------------------------------------------------------------------
module gap_buffer_text_store_top_tb;
   import gbts_pkg::*;

   localparam int Depth = 4096;

   typedef struct {
      status_type status;
      logic [7:0] read_byte;
      logic [12:0] content_length;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_mode = '0;
   logic [12:0] req_position = '0;
   logic [7:0] req_data_byte = '0;
   logic [12:0] req_length = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_status;
   logic [7:0] rsp_read_byte;
   logic [12:0] rsp_content_length;

   gap_buffer_text_store_top #(.CAPACITY(Depth)) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_mode(req_mode),
      .req_position(req_position),
      .req_data_byte(req_data_byte),
      .req_length(req_length),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_read_byte(rsp_read_byte),
      .rsp_content_length(rsp_content_length)
   );

   // Requests waiting to be offered, and result words still owed by the block.
   item_type edit_queue[$];
   answer_type owed_answers[$];

   // The predicted text: bytes below gap_lo and from gap_hi to the end.
   logic [7:0] text_mem [0:Depth-1];
   int gap_lo = 0;
   int gap_hi = Depth;

   // Length of the text as the generator sees it, after every queued request.
   int plan_len = 0;
   int plan_pos = 0;

   int mismatches = 0;
   bit quiet = 1'b0;
   bit hold_ask = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   // Slides the gap so that it begins at logical index pos. Bytes cross the
   // gap in an order that never overwrites a byte not yet moved.
   task automatic slide_gap(input int pos);
      int delta;
      int width;
      width = gap_hi - gap_lo;
      if (pos < gap_lo) begin
         delta = gap_lo - pos;
         for (int i = delta - 1; i >= 0; i--) text_mem[gap_hi - delta + i] = text_mem[pos + i];
      end else if (pos > gap_lo) begin
         delta = pos - gap_lo;
         for (int i = 0; i < delta; i++) text_mem[gap_lo + i] = text_mem[gap_hi + i];
      end
      gap_lo = pos;
      gap_hi = pos + width;
   endtask

   // Applies one accepted request to the predicted text and queues the word
   // the block must answer with.
   task automatic apply_edit(input item_type it);
      answer_type ans;
      int held;
      int pos;
      int run;
      held = gap_lo + (Depth - gap_hi);
      pos = int'(it.position);
      run = int'(it.length);
      ans.status = STATUS_OK;
      ans.read_byte = 8'd0;
      case (it.kind)
         KIND_INSERT: begin
            // The range check wins over the full check.
            if (pos > held) ans.status = STATUS_RANGE;
            else if (gap_lo == gap_hi) ans.status = STATUS_FULL;
            else begin
               slide_gap(pos);
               text_mem[gap_lo] = it.data_byte;
               gap_lo++;
            end
         end
         KIND_DELETE: begin
            if (pos + run > held) ans.status = STATUS_RANGE;
            else begin
               slide_gap(pos);
               gap_hi += run;
            end
         end
         KIND_READ: begin
            if (pos >= held) ans.status = STATUS_RANGE;
            else if (pos < gap_lo) ans.read_byte = text_mem[pos];
            else ans.read_byte = text_mem[pos + (gap_hi - gap_lo)];
         end
         default: ans.status = STATUS_RANGE;
      endcase
      ans.content_length = 13'(gap_lo + (Depth - gap_hi));
      owed_answers.push_back(ans);
   endtask

   // Queues one request and tracks the text length it leaves behind, so
   // later positions can be aimed inside or just outside the text.
   task automatic queue_edit(input kind_type kind, input int pos, input int data,
                             input int run);
      item_type it;
      it.kind = kind;
      it.position = 13'(pos);
      it.data_byte = 8'(data);
      it.length = 13'(run);
      edit_queue.push_back(it);
      if (kind == KIND_INSERT && pos <= plan_len && plan_len < Depth) plan_len++;
      if (kind == KIND_DELETE && pos + run <= plan_len) plan_len -= run;
      plan_pos = pos;
   endtask

   // Picks a position: mostly close to the last edit, since gap moves cost
   // cycles per byte, sometimes anywhere in the text, sometimes anywhere.
   function automatic int pick_position(input int span);
      int r;
      int p;
      r = $urandom_range(0, 99);
      if (r < 70) begin
         p = plan_pos + $urandom_range(0, 8) - 4;
         if (p < 0) p = 0;
         if (p > span) p = span;
      end else if (r < 92) p = $urandom_range(0, span);
      else p = $urandom_range(0, 8191);
      return p;
   endfunction

   task automatic queue_random_edit();
      int k;
      int ins_cut;
      int del_cut;
      int run;
      int r;
      bit crowded;
      crowded = plan_len > 300;
      ins_cut = crowded ? 25 : 50;
      del_cut = ins_cut + (crowded ? 35 : 12);
      k = $urandom_range(0, 99);
      if (k < ins_cut) begin
         queue_edit(KIND_INSERT, pick_position(plan_len), $urandom_range(0, 255), 0);
      end else if (k < del_cut) begin
         r = $urandom_range(0, 99);
         if (r < 80) run = $urandom_range(0, 4);
         else if (r < 95) run = $urandom_range(0, 64);
         else run = $urandom_range(0, 8191);
         queue_edit(KIND_DELETE, pick_position(plan_len), $urandom_range(0, 255), run);
      end else if (k < 95) begin
         queue_edit(KIND_READ, pick_position(plan_len > 0 ? plan_len - 1 : 0),
                    $urandom_range(0, 255), $urandom_range(0, 8191));
      end else begin
         queue_edit(KIND_BAD, $urandom_range(0, 8191), $urandom_range(0, 255),
                    $urandom_range(0, 8191));
      end
   endtask

   // Checks between edges, so every update made at the last edge is visible.
   task automatic drain();
      while (edit_queue.size() != 0 || req_valid || owed_answers.size() != 0)
         @(negedge clock);
   endtask

   // Driver: offers queued words, keeping a stalled word steady, and inserts
   // random idle bursts between words unless the run is in its quiet part.
   item_type drive_item = '0;
   int drive_idle = 0;
   bit drive_next;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         drive_next = req_valid;
         if (req_valid && !req_stall) begin
            apply_edit(drive_item);
            drive_next = 1'b0;
         end
         if (!drive_next) begin
            if (drive_idle > 0) begin
               drive_idle--;
            end else if (edit_queue.size() != 0) begin
               if (!quiet && $urandom_range(0, 9) == 0) begin
                  drive_idle = $urandom_range(0, 16);
               end else begin
                  drive_item = edit_queue.pop_front();
                  drive_next = 1'b1;
               end
            end
         end
         req_valid <= drive_next;
         req_mode <= drive_item.kind;
         req_position <= drive_item.position;
         req_data_byte <= drive_item.data_byte;
         req_length <= drive_item.length;
      end
   end

   // Monitor: checks every accepted result word against the oldest owed one
   // and drives rsp_stall, including one long hold-off that backs the block up.
   int stall_left = 0;
   int hold_left = 0;
   bit hold_taken = 1'b0;
   bit stall_next;
   answer_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (owed_answers.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result word: status %0d byte %0d length %0d",
                           rsp_status, rsp_read_byte, rsp_content_length);
            end else begin
               want = owed_answers.pop_front();
               if (rsp_status !== want.status || rsp_read_byte !== want.read_byte ||
                   rsp_content_length !== want.content_length) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("result mismatch: status %0d/%0d byte %0d/%0d length %0d/%0d",
                              want.status, rsp_status, want.read_byte, rsp_read_byte,
                              want.content_length, rsp_content_length);
               end
            end
         end
         if (hold_ask && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            stall_next = 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            stall_next = 1'b1;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 16);
            stall_next = 1'b1;
         end else begin
            stall_next = 1'b0;
         end
         rsp_stall <= stall_next;
      end
   end

   initial begin
      #1_000_000_000;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      int text_len;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty-text range errors, a zero-byte delete, edits at both
      // ends, extreme bytes, reads at and past the end, the unused mode and
      // the largest field values.
      queue_edit(KIND_INSERT, 1, 8'h55, 0);
      queue_edit(KIND_READ, 0, 0, 0);
      queue_edit(KIND_DELETE, 0, 0, 0);
      queue_edit(KIND_INSERT, 0, 8'h41, 0);
      queue_edit(KIND_INSERT, 1, 8'hFF, 0);
      queue_edit(KIND_INSERT, 0, 8'h00, 0);
      queue_edit(KIND_INSERT, 3, 8'h80, 0);
      for (int i = 0; i < 5; i++) queue_edit(KIND_READ, i, 0, 0);
      queue_edit(KIND_DELETE, 1, 0, 2);
      queue_edit(KIND_DELETE, 2, 0, 1);
      queue_edit(KIND_DELETE, 2, 0, 0);
      queue_edit(KIND_READ, 1, 0, 0);
      queue_edit(KIND_BAD, 0, 8'hFF, 8191);
      queue_edit(KIND_INSERT, 8191, 8'hFF, 8191);
      queue_edit(KIND_DELETE, 0, 8'hFF, 8191);
      queue_edit(KIND_READ, 8191, 8'hFF, 8191);
      queue_edit(KIND_DELETE, 0, 0, 2);
      queue_edit(KIND_READ, 0, 0, 0);

      for (int i = 0; i < 550; i++) queue_random_edit();
      // The receiver holds off while the sender still has plenty to offer.
      hold_ask = 1'b1;
      for (int i = 0; i < 350; i++) queue_random_edit();

      // The sender pauses until every owed word has come back.
      drain();

      // Grow the text by appending, then hit the range cases at its end and
      // empty it with one delete of the whole text.
      for (int i = 0; i < 64; i++) queue_edit(KIND_INSERT, plan_len, $urandom_range(0, 255), 0);
      text_len = plan_len;
      queue_edit(KIND_INSERT, text_len + 1, 8'h22, 0);
      queue_edit(KIND_READ, text_len - 1, 0, 0);
      queue_edit(KIND_READ, text_len, 0, 0);
      queue_edit(KIND_INSERT, Depth + 1, 8'h22, 0);
      queue_edit(KIND_DELETE, 0, 0, text_len);
      drain();

      // Last part without any idling on either side.
      quiet = 1'b1;
      repeat (20) @(posedge clock);
      for (int i = 0; i < 600; i++) queue_random_edit();
      drain();
      repeat (200) @(posedge clock);

      if (mismatches == 0 && owed_answers.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
